// File: rtl/core/scpd_pkg.sv
`default_nettype none

package scpd_pkg;

	// Width of one audio sample.
	localparam int SampleBits = 16;
	// Compare width that holds both a sample and the negated 15-bit threshold.
	localparam int CmpBits = ((SampleBits > 15) ? SampleBits : 15) + 2;

	// Result queue between the trigger and the output port.
	localparam int QueueDepth   = 4;
	localparam int QueuePtrBits = $clog2(QueueDepth);
	localparam int QueueCntBits = $clog2(QueueDepth + 1);

	// Register indexes of the configuration port.
	localparam logic [1:0] CfgThreshold  = 2'd0;
	localparam logic [1:0] CfgPhaseStep  = 2'd1;
	localparam logic [1:0] CfgStaleLimit = 2'd2;

	localparam logic [14:0] ThresholdReset  = 15'd66;
	localparam logic [31:0] PhaseStepReset  = 32'd39370533;
	localparam logic [23:0] StaleLimitReset = 24'd9600;

	localparam logic [23:0] ElapsedMax = 24'hFFFFFF;

	typedef enum logic [1:0] {
		KindRise  = 2'd0,
		KindPeak  = 2'd1,
		KindStale = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                         kind;
		logic [15:0]                   angle;
		logic [23:0]                   elapsed;
		logic signed [SampleBits-1:0]  peak_value;
		logic [31:0]                   peak_time;
		logic                          last;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	// Results produced by one sample: count is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [23:0] sat24(input logic [31:0] d);
		logic [23:0] r;
		r = (d[31:24] != 8'd0) ? ElapsedMax : d[23:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/strobe_crossing_phase_detector.sv
`default_nettype none

// Channel   Handshake                 Payload
// input     in_valid / in_stall       sample
// output    out_valid / out_stall     kind, angle, elapsed, peak_value, peak_time, last
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One sample word is taken every cycle unless the input stalls. A word waits in the
// input register until it is processed, when its results enter the result queue; a
// sample that causes two results gives two output words. The input stalls only while
// fewer than two queue slots are free. Reset clears the trigger state and loads the
// register defaults; no clearing pass follows. Configuration writes are always ready.

module strobe_crossing_phase_detector (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Sample input.
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [scpd_pkg::SampleBits-1:0] sample,
	// Result output.
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [1:0]                                  kind,
	output logic [15:0]                                 angle,
	output logic [23:0]                                 elapsed,
	output logic signed [scpd_pkg::SampleBits-1:0]      peak_value,
	output logic [31:0]                                 peak_time,
	output logic                                        last,
	// Register writes.
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [1:0]                             cfg_index,
	input  wire logic [31:0]                            cfg_data
);

	// Input register: one sample word waiting for the trigger.
	logic                                   valid_s1;
	logic signed [scpd_pkg::SampleBits-1:0] sample_s1;

	logic               room2;
	logic               fire;
	logic               pop;
	logic               not_empty;
	scpd_pkg::cfg_wr_t  cfg;
	scpd_pkg::push_t    push;
	scpd_pkg::result_t  head;

	// The held word is processed whenever the queue can take both possible results.
	assign fire      = valid_s1 && room2;
	assign in_stall  = valid_s1 && !room2;
	assign pop       = not_empty && !out_stall;
	assign cfg_ready = 1'b1;

	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
		end
	end

	scpd_trigger u_trigger (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.sample (sample_s1),
		.push   (push)
	);

	// The queue head is the output word; it holds while the output stalls.
	scpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign out_valid  = not_empty;
	assign kind       = head.kind;
	assign angle      = head.angle;
	assign elapsed    = head.elapsed;
	assign peak_value = head.peak_value;
	assign peak_time  = head.peak_time;
	assign last       = head.last;

	// A held word is never dropped: it is either processed or still held next cycle.
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(sample_s1))
		else $error("held sample word lost");

endmodule

`default_nettype wire

// File: rtl/core/scpd_trigger.sv
`default_nettype none

module scpd_trigger (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire scpd_pkg::cfg_wr_t                      cfg,
	input  wire logic                                   fire,
	input  wire logic signed [scpd_pkg::SampleBits-1:0] sample,
	output scpd_pkg::push_t                             push
);

	logic [14:0] threshold_q;
	logic [31:0] phase_step_q;
	logic [23:0] stale_limit_q;

	logic                                   is_high_q;
	logic [31:0]                            count_q;
	logic [31:0]                            phase_q;
	logic [31:0]                            last_rise_q;
	logic [31:0]                            last_refresh_q;
	logic                                   peak_seen_q;
	logic signed [scpd_pkg::SampleBits-1:0] peak_level_q;
	logic [31:0]                            peak_at_q;

	logic signed [scpd_pkg::CmpBits-1:0] s_ext;
	logic signed [scpd_pkg::CmpBits-1:0] thr_ext;
	logic                                fall;
	logic                                above;
	logic                                rise;
	logic                                take_peak;
	logic                                peak_out;
	logic                                stale;
	logic [31:0]                         next_t;
	logic [31:0]                         refresh_base;
	logic [31:0]                         gap;
	scpd_pkg::result_t                   ev_res;
	scpd_pkg::result_t                   stale_res;

	always_comb begin
		s_ext        = scpd_pkg::CmpBits'(sample);
		thr_ext      = scpd_pkg::CmpBits'(threshold_q);
		// The fall test wins, so with a zero threshold a zero sample while high is a fall.
		fall         = is_high_q && (s_ext <= -thr_ext);
		above        = s_ext >= thr_ext;
		rise         = !fall && above && !is_high_q;
		take_peak    = !fall && above && (!peak_seen_q || (sample >= peak_level_q));
		peak_out     = fall && peak_seen_q;
		next_t       = count_q + 32'd1;
		refresh_base = rise ? count_q : last_refresh_q;
		gap          = next_t - refresh_base;
		stale        = gap > {8'd0, stale_limit_q};

		ev_res = '0;
		if (peak_out) begin
			ev_res.kind       = scpd_pkg::KindPeak;
			ev_res.peak_value = peak_level_q;
			ev_res.peak_time  = peak_at_q;
		end else begin
			ev_res.kind    = scpd_pkg::KindRise;
			ev_res.angle   = phase_q[31:16];
			ev_res.elapsed = scpd_pkg::sat24(count_q - last_rise_q);
		end
		ev_res.last = !stale;

		stale_res         = '0;
		stale_res.kind    = scpd_pkg::KindStale;
		stale_res.elapsed = scpd_pkg::sat24(gap);
		stale_res.last    = 1'b1;

		if (peak_out || rise) begin
			push.first = ev_res;
		end else begin
			push.first = stale_res;
		end
		push.second = stale_res;
		push.count  = fire ? (2'({1'b0, peak_out || rise}) + 2'({1'b0, stale})) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= scpd_pkg::ThresholdReset;
			phase_step_q   <= scpd_pkg::PhaseStepReset;
			stale_limit_q  <= scpd_pkg::StaleLimitReset;
			is_high_q      <= 1'b0;
			count_q        <= '0;
			phase_q        <= '0;
			last_rise_q    <= '0;
			last_refresh_q <= '0;
			peak_seen_q    <= 1'b0;
			peak_level_q   <= '0;
			peak_at_q      <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					scpd_pkg::CfgThreshold:  threshold_q   <= cfg.data[14:0];
					scpd_pkg::CfgPhaseStep:  phase_step_q  <= cfg.data;
					scpd_pkg::CfgStaleLimit: stale_limit_q <= cfg.data[23:0];
					default: ;
				endcase
			end
			if (fire) begin
				if (fall) begin
					is_high_q   <= 1'b0;
					peak_seen_q <= 1'b0;
				end else begin
					if (take_peak) begin
						peak_seen_q  <= 1'b1;
						peak_level_q <= sample;
						peak_at_q    <= count_q;
					end
					if (rise) begin
						is_high_q   <= 1'b1;
						last_rise_q <= count_q;
					end
				end
				if (stale) begin
					last_refresh_q <= next_t;
				end else if (rise) begin
					last_refresh_q <= count_q;
				end
				count_q <= next_t;
				phase_q <= phase_q + phase_step_q;
			end
		end
	end

	// Two results from one sample are an edge event followed by a stale refresh.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.second.kind == scpd_pkg::KindStale &&
			push.first.kind != scpd_pkg::KindStale)
		else $error("two results without trailing stale refresh");

	// Only the final result of a sample is marked last.
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> !push.first.last && push.second.last)
		else $error("last mark misplaced on a result pair");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd1 |-> push.first.last)
		else $error("single result not marked last");

endmodule

`default_nettype wire

// File: rtl/core/scpd_queue.sv
`default_nettype none

module scpd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scpd_pkg::push_t   push,
	input  wire logic              pop,
	output scpd_pkg::result_t      head,
	output logic                   not_empty,
	output logic                   room2
);

	scpd_pkg::result_t                   mem [scpd_pkg::QueueDepth];
	logic [scpd_pkg::QueuePtrBits-1:0]   wr_q;
	logic [scpd_pkg::QueuePtrBits-1:0]   rd_q;
	logic [scpd_pkg::QueueCntBits-1:0]   cnt_q;

	assign head      = mem[rd_q];
	assign not_empty = cnt_q != '0;
	assign room2     = cnt_q <= scpd_pkg::QueueCntBits'(scpd_pkg::QueueDepth - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + 1'b1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + scpd_pkg::QueuePtrBits'(push.count);
			rd_q  <= rd_q + scpd_pkg::QueuePtrBits'(pop);
			cnt_q <= cnt_q + scpd_pkg::QueueCntBits'(push.count) - scpd_pkg::QueueCntBits'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= scpd_pkg::QueueCntBits'(scpd_pkg::QueueDepth))
		else $error("result queue overflow");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.count == 2'd0 |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not reduce queue fill");

endmodule

`default_nettype wire
